[src/gti_pkg.sv]
// shared types and constants for the grid interpolator
`timescale 1ns / 1ps
package gti_pkg;
  localparam logic [1:0] MODE_TRILINEAR = 2'd1;
  localparam logic [1:0] MODE_TRIQUAD   = 2'd2;
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_INTERP = 1'b1;
  localparam int   ACC_W      = 56;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic        command;
    logic [14:0] grid_address;
    logic [31:0] sample_value;
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    logic [31:0] z_pos;
  } in_item_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_READ  = 8'b0000_0010,
    ST_MUL1  = 8'b0000_0100,
    ST_MUL2  = 8'b0000_1000,
    ST_MUL3  = 8'b0001_0000,
    ST_STORE = 8'b0010_0000,
    ST_SAT   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;
endpackage

[src/gti_if.sv]
// valid/ready channel interfaces for input and result items
`timescale 1ns / 1ps
interface gti_in_if;
  import gti_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gti_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] interp_value;
  modport source (output valid, output interp_value, input ready);
  modport sink (input valid, input interp_value, output ready);
endinterface

[src/gti_grid_mem.sv]
// single-port grid sample memory with registered read
`timescale 1ns / 1ps
module gti_grid_mem #(
  parameter int AW = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);
  logic [31:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[src/grid3d_trilinear_triquadratic_interp.sv]
// top level: periodic 3d grid interpolator, trilinear and triquadratic
`timescale 1ns / 1ps
// A write item stores one Q16.16 sample at its transfer edge, so writes can follow each
// other every cycle while no interpolation is in progress. An interpolate item reads its
// neighbours from a single-port memory one per cycle, through its registered read port,
// and blends them in a shared multiply unit that steps through MUL1, MUL2, MUL3 and
// STORE for each blend, then saturates the result in SAT and presents it in OUT.
// Trilinear: 8 reads and 7 blends. Triquadratic: 27 reads and 13 three-point
// evaluations. One item is in flight at a time and the next one is taken in the
// cycle the result appears. A new input transfer is taken while a result waits; the
// following result holds in the saturate stage until the waiting one is taken.
module grid3d_trilinear_triquadratic_interp #(
  parameter int LOG_NY = 5,
  parameter int LOG_NX = 5,
  parameter int LOG_NZ = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  gti_in_if.sink      in_ch,
  gti_out_if.source   out_ch
);
  import gti_pkg::*;

  localparam int AW = LOG_NY + LOG_NX + LOG_NZ;

  state_t      state_r, state_nxt;
  logic [1:0]  mode_r;
  logic        quad_r;
  logic [LOG_NX-1:0] xi_r;
  logic [LOG_NY-1:0] yi_r;
  logic [LOG_NZ-1:0] zi_r;
  logic signed [16:0] rx_r, ry_r, rz_r;
  logic [4:0]  rd_cnt_r;
  logic        rd_vld_r;
  logic [4:0]  rd_idx_r;
  acc_t        buf_r [0:26];
  logic [3:0]  op_cnt_r;
  acc_t        m_r, c_r, p_r;
  logic signed [16:0] r_r;
  acc_t        t1_r, t2_r, t3_r;
  acc_t        res_r;
  logic        out_vld_r;
  logic [31:0] out_val_r;

  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [31:0]   mem_rdata;

  gti_grid_mem #(.AW(AW)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(in_ch.data.sample_value),
    .rdata(mem_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  logic in_xfer;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign mem_we  = in_xfer && (in_ch.data.command == CMD_WRITE);

  // result register free for a new value
  logic out_free;
  assign out_free = !out_vld_r || out_ch.ready;

  // neighbour offsets for the current read
  logic [1:0] dx, dy, dz;
  logic [4:0] rem9;
  always_comb begin
    rem9 = '0;
    if (quad_r) begin
      if (rd_cnt_r >= 5'd18) begin
        dz   = 2'd2;
        rem9 = rd_cnt_r - 5'd18;
      end else if (rd_cnt_r >= 5'd9) begin
        dz   = 2'd1;
        rem9 = rd_cnt_r - 5'd9;
      end else begin
        dz   = 2'd0;
        rem9 = rd_cnt_r;
      end
      if (rem9 >= 5'd6) begin
        dx = 2'd2;
        dy = 2'(rem9 - 5'd6);
      end else if (rem9 >= 5'd3) begin
        dx = 2'd1;
        dy = 2'(rem9 - 5'd3);
      end else begin
        dx = 2'd0;
        dy = 2'(rem9);
      end
    end else begin
      dz = {1'b0, rd_cnt_r[2]};
      dy = {1'b0, rd_cnt_r[1]};
      dx = {1'b0, rd_cnt_r[0]};
    end
  end

  logic [LOG_NX-1:0] ax;
  logic [LOG_NY-1:0] ay;
  logic [LOG_NZ-1:0] az;
  always_comb begin
    ax = xi_r + LOG_NX'(dx) - LOG_NX'(quad_r);
    ay = yi_r + LOG_NY'(dy) - LOG_NY'(quad_r);
    az = zi_r + LOG_NZ'(dz) - LOG_NZ'(quad_r);
    if (state_r == ST_IDLE) begin
      mem_addr = in_ch.data.grid_address[AW-1:0];
    end else begin
      mem_addr = {az, ax, ay};
    end
  end

  // coordinate decode
  logic [LOG_NX-1:0] cx;
  logic [LOG_NY-1:0] cy;
  logic [LOG_NZ-1:0] cz;
  logic signed [16:0] fx, fy, fz;
  function automatic logic signed [16:0] off_of(input logic [31:0] d, input int lg);
    logic signed [31:0] s;
    begin
      s = $signed(d) >>> (16 - lg);
      off_of = 17'(s);
    end
  endfunction
  always_comb begin
    logic [32:0] tx, ty, tz;
    logic [31:0] bx, by, bz;
    if (mode_r == MODE_TRIQUAD) begin
      tx = ({1'b0, in_ch.data.x_pos} + (33'd1 << (31 - LOG_NX))) >> (32 - LOG_NX);
      ty = ({1'b0, in_ch.data.y_pos} + (33'd1 << (31 - LOG_NY))) >> (32 - LOG_NY);
      tz = ({1'b0, in_ch.data.z_pos} + (33'd1 << (31 - LOG_NZ))) >> (32 - LOG_NZ);
      bx = 32'(tx << (32 - LOG_NX));
      by = 32'(ty << (32 - LOG_NY));
      bz = 32'(tz << (32 - LOG_NZ));
      cx = tx[LOG_NX-1:0];
      cy = ty[LOG_NY-1:0];
      cz = tz[LOG_NZ-1:0];
      fx = off_of(in_ch.data.x_pos - bx, LOG_NX);
      fy = off_of(in_ch.data.y_pos - by, LOG_NY);
      fz = off_of(in_ch.data.z_pos - bz, LOG_NZ);
    end else begin
      tx = '0; ty = '0; tz = '0; bx = '0; by = '0; bz = '0;
      cx = in_ch.data.x_pos[31 -: LOG_NX];
      cy = in_ch.data.y_pos[31 -: LOG_NY];
      cz = in_ch.data.z_pos[31 -: LOG_NZ];
      fx = {1'b0, in_ch.data.x_pos[31-LOG_NX -: 16]};
      fy = {1'b0, in_ch.data.y_pos[31-LOG_NY -: 16]};
      fz = {1'b0, in_ch.data.z_pos[31-LOG_NZ -: 16]};
    end
  end

  // operation schedule: sources in buf, destination, axis
  logic [4:0] last_rd;
  logic [3:0] last_op;
  assign last_rd = quad_r ? 5'd26 : 5'd7;
  assign last_op = quad_r ? 4'd12 : 4'd6;

  logic [4:0] s0, s1, s2, dst;
  logic [1:0] axis;
  always_comb begin
    s2 = '0;
    if (quad_r) begin
      if (op_cnt_r < 4'd9) begin
        s0 = 5'(op_cnt_r * 3); s1 = 5'(op_cnt_r * 3 + 1); s2 = 5'(op_cnt_r * 3 + 2);
        dst = 5'(op_cnt_r * 3); axis = 2'd1;
      end else if (op_cnt_r < 4'd12) begin
        s0 = 5'((op_cnt_r - 9) * 9); s1 = 5'((op_cnt_r - 9) * 9 + 3);
        s2 = 5'((op_cnt_r - 9) * 9 + 6); dst = 5'((op_cnt_r - 9) * 9); axis = 2'd0;
      end else begin
        s0 = 5'd0; s1 = 5'd9; s2 = 5'd18; dst = 5'd0; axis = 2'd2;
      end
    end else begin
      if (op_cnt_r < 4'd4) begin
        s0 = 5'(op_cnt_r * 2); s1 = 5'(op_cnt_r * 2 + 1); dst = s0; axis = 2'd0;
      end else if (op_cnt_r < 4'd6) begin
        s0 = 5'((op_cnt_r - 4) * 4); s1 = s0 + 5'd2; dst = s0; axis = 2'd1;
      end else begin
        s0 = 5'd0; s1 = 5'd4; dst = 5'd0; axis = 2'd2;
      end
    end
  end

  logic signed [16:0] r_sel;
  always_comb begin
    case (axis)
      2'd0:    r_sel = rx_r;
      2'd1:    r_sel = ry_r;
      default: r_sel = rz_r;
    endcase
  end

  // shared multiply path
  acc_t diff_h, diff_s, prod1, prod2, prod3;
  assign diff_h = quad_r ? p_r - m_r : c_r - m_r;
  assign diff_s = p_r + m_r - (c_r <<< 1);
  assign prod1  = acc_t'(diff_h * r_r);
  assign prod2  = acc_t'(diff_s * r_r);
  assign prod3  = acc_t'((t2_r >>> 16) * r_r);

  acc_t op_res;
  assign op_res = quad_r ? c_r + (t1_r >>> 17) + (t3_r >>> 17)
                         : m_r + (t1_r >>> 16);

  acc_t sat_lo, sat_hi;
  assign sat_hi = acc_t'(32'sh7fffffff);
  assign sat_lo = -acc_t'(33'sh080000000);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_ch.data.command == CMD_INTERP &&
            (mode_r == MODE_TRILINEAR || mode_r == MODE_TRIQUAD)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:  if (!(rd_cnt_r <= last_rd) && !rd_vld_r) state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_MUL3;
      ST_MUL3:  state_nxt = ST_STORE;
      ST_STORE: state_nxt = (op_cnt_r == last_op) ? ST_SAT : ST_MUL1;
      ST_SAT:   state_nxt = out_free ? ST_OUT : ST_SAT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= MODE_TRILINEAR;
      out_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      rd_cnt_r  <= '0;
      op_cnt_r  <= '0;
      quad_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (out_vld_r && out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          rd_cnt_r <= '0;
          op_cnt_r <= '0;
          rd_vld_r <= 1'b0;
          quad_r   <= (mode_r == MODE_TRIQUAD);
        end
        ST_READ: begin
          rd_vld_r <= (rd_cnt_r <= last_rd);
          rd_idx_r <= rd_cnt_r;
          if (rd_cnt_r <= last_rd) begin
            rd_cnt_r <= rd_cnt_r + 5'd1;
          end
        end
        ST_STORE: op_cnt_r <= op_cnt_r + 4'd1;
        ST_OUT:   out_vld_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      xi_r <= cx; yi_r <= cy; zi_r <= cz;
      rx_r <= fx; ry_r <= fy; rz_r <= fz;
    end
    if (state_r == ST_READ && rd_vld_r) begin
      buf_r[rd_idx_r] <= acc_t'($signed(mem_rdata));
    end
    case (state_r)
      ST_MUL1: begin
        m_r <= buf_r[s0];
        c_r <= buf_r[s1];
        p_r <= buf_r[s2];
        r_r <= r_sel;
      end
      ST_MUL2: begin
        t1_r <= prod1;
        t2_r <= prod2;
      end
      ST_MUL3:  t3_r <= prod3;
      ST_STORE: begin
        buf_r[dst] <= op_res;
        res_r      <= op_res;
      end
      ST_SAT: begin
        if (out_free) begin
          if (res_r > sat_hi) begin
            out_val_r <= 32'h7fffffff;
          end else if (res_r < sat_lo) begin
            out_val_r <= 32'h80000000;
          end else begin
            out_val_r <= res_r[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.interp_value = out_val_r;
endmodule

[tb/sv/testbench.sv]
// testbench for the periodic 3d grid interpolator: directed table then random items
`timescale 1ns / 1ps
module testbench;
  import gti_pkg::*;

  localparam int LY = 5, LX = 5, LZ = 5;
  localparam int GBITS = LY + LX + LZ;
  localparam int GSIZE = 1 << GBITS;
  localparam int REGION = 512;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_wdata;

  gti_in_if in_ch();
  gti_out_if out_ch();

  grid3d_trilinear_triquadratic_interp #(.LOG_NY(LY), .LOG_NX(LX), .LOG_NZ(LZ)) u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // predictor state
  logic [31:0] grid_copy [GSIZE];
  logic [1:0]  mode_copy;

  logic [31:0] expected_values[$];
  int          mismatch_count;
  int          idle_cycles;
  bit          no_idle;
  bit          hold_off;

  typedef struct {
    in_item_t    item;
    bit          known;
    logic [31:0] value;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sample_at(int xi, int yi, int zi);
    int a;
    a = (yi & ((1 << LY) - 1)) | ((xi & ((1 << LX) - 1)) << LY) |
        ((zi & ((1 << LZ) - 1)) << (LY + LX));
    return longint'(signed'(grid_copy[a]));
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return a + fshift((b - a) * f, 16);
  endfunction

  function automatic longint quad3(longint m, longint c, longint p, longint r);
    longint h, s;
    h = p - m;
    s = p + m - 2 * c;
    return c + fshift(h * r, 17) + fshift(fshift(s * r, 16) * r, 17);
  endfunction

  function automatic void cell_split(logic [31:0] pos, int lg, output int cell_idx,
                                     output longint frac);
    logic [31:0] sh;
    cell_idx = int'(pos >> (32 - lg));
    sh = pos << lg;
    frac = longint'(sh >> 16);
  endfunction

  function automatic void node_split(logic [31:0] pos, int lg, output int node,
                                     output longint off);
    logic [32:0] t;
    logic [31:0] base, d;
    t = ({1'b0, pos} + (33'd1 << (31 - lg))) >> (32 - lg);
    base = 32'(t << (32 - lg));
    d = pos - base;
    node = int'(t);
    off = fshift(longint'(signed'(d)), 16 - lg);
  endfunction

  // returns 1 when the item yields an interpolated value
  function automatic bit interpolate(in_item_t it, output logic [31:0] res);
    int xi, yi, zi;
    longint rx, ry, rz, v;
    longint c00, c01, c10, c11, e0, e1;
    longint lx[3], lz[3];
    res = '0;
    if (it.command == CMD_WRITE) begin
      grid_copy[it.grid_address & (GSIZE - 1)] = it.sample_value;
      return 1'b0;
    end
    if (mode_copy == MODE_TRILINEAR) begin
      cell_split(it.x_pos, LX, xi, rx);
      cell_split(it.y_pos, LY, yi, ry);
      cell_split(it.z_pos, LZ, zi, rz);
      c00 = blend(sample_at(xi, yi, zi), sample_at(xi + 1, yi, zi), rx);
      c01 = blend(sample_at(xi, yi + 1, zi), sample_at(xi + 1, yi + 1, zi), rx);
      c10 = blend(sample_at(xi, yi, zi + 1), sample_at(xi + 1, yi, zi + 1), rx);
      c11 = blend(sample_at(xi, yi + 1, zi + 1), sample_at(xi + 1, yi + 1, zi + 1), rx);
      e0 = blend(c00, c01, ry);
      e1 = blend(c10, c11, ry);
      v = blend(e0, e1, rz);
    end else if (mode_copy == MODE_TRIQUAD) begin
      node_split(it.x_pos, LX, xi, rx);
      node_split(it.y_pos, LY, yi, ry);
      node_split(it.z_pos, LZ, zi, rz);
      for (int dz = 0; dz < 3; dz++) begin
        for (int dx = 0; dx < 3; dx++)
          lx[dx] = quad3(sample_at(xi + dx - 1, yi - 1, zi + dz - 1),
                         sample_at(xi + dx - 1, yi, zi + dz - 1),
                         sample_at(xi + dx - 1, yi + 1, zi + dz - 1), ry);
        lz[dz] = quad3(lx[0], lx[1], lx[2], rx);
      end
      v = quad3(lz[0], lz[1], lz[2], rz);
    end else begin
      return 1'b0;
    end
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    res = v[31:0];
    return 1'b1;
  endfunction

  function automatic bit take_gap();
    return !no_idle && ($urandom_range(99) < 12);
  endfunction

  // address in the 8 x 8 x 8 block of nodes 28..31, 0..3 around the origin
  function automatic int region_addr(int i);
    int ax, ay, az;
    ay = ((i & 7) + 28) & ((1 << LY) - 1);
    ax = (((i >> 3) & 7) + 28) & ((1 << LX) - 1);
    az = (((i >> 6) & 7) + 28) & ((1 << LZ) - 1);
    return ay | (ax << LY) | (az << (LY + LX));
  endfunction

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && !take_gap();
      if (out_ch.valid && out_ch.ready) begin
        if (expected_values.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected transfer: actual %h", out_ch.interp_value);
        end else begin
          if (out_ch.interp_value !== expected_values[0]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("interp_value: expected %h actual %h",
                       expected_values[0], out_ch.interp_value);
          end
          void'(expected_values.pop_front());
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("grid3d_trilinear_triquadratic_interp: mismatch");
        $finish;
      end
    end
  end

  task automatic send(in_item_t it, bit known, logic [31:0] value);
    logic [31:0] res;
    bit has;
    if (take_gap()) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (take_gap());
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    has = interpolate(it, res);
    if (has) begin
      if (known && res !== value) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("table row: expected %h predicted %h", value, res);
      end
      expected_values.push_back(res);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_copy = m;
  endtask

  function automatic in_item_t write_item(int addr, logic [31:0] v);
    in_item_t it;
    it = '0;
    it.command = CMD_WRITE;
    it.grid_address = 15'(addr);
    it.sample_value = v;
    it.x_pos = $urandom();
    it.y_pos = $urandom();
    it.z_pos = $urandom();
    return it;
  endfunction

  function automatic in_item_t interp_item(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it.command = CMD_INTERP;
    it.grid_address = 15'($urandom());
    it.sample_value = $urandom();
    it.x_pos = x;
    it.y_pos = y;
    it.z_pos = z;
    return it;
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom();
    endcase
  endfunction

  // positions in cells 30, 31, 0 and 1 only read the filled block
  function automatic logic [31:0] pick_pos();
    logic [4:0] top;
    top = 5'($urandom_range(3) + 30);
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return {top, 27'h0};
      3: return {top, 27'h4000000};
      default: return {top, 27'($urandom())};
    endcase
  endfunction

  dir_row_t dir_table[$];

  initial begin
    dir_row_t row;
    logic [1:0] m;
    int n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = MODE_TRILINEAR;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    no_idle = 1'b0;
    hold_off = 1'b0;
    mode_copy = MODE_TRILINEAR;
    for (int i = 0; i < GSIZE; i++) begin
      grid_copy[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // fill the block around the origin that every interpolation reads
    for (int i = 0; i < REGION; i++) begin
      n = region_addr(i);
      in_ch.valid <= 1'b1;
      in_ch.data <= write_item(n, 32'(n) << 8);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      void'(interpolate(write_item(n, 32'(n) << 8), row.value));
    end
    in_ch.valid <= 1'b0;

    // directed table; known values: at a node the value is the stored sample
    row.known = 1'b1; row.item = interp_item(0, 0, 0); row.value = 32'h0;
    dir_table.push_back(row);
    row.item = write_item(32'h7fff, 32'h7fffffff); row.value = '0;
    dir_table.push_back(row);
    row.item = write_item(0, 32'h80000000);
    dir_table.push_back(row);
    row.item = interp_item(0, 0, 0); row.value = 32'h80000000;
    dir_table.push_back(row);
    row.item = interp_item(32'hf8000000, 32'hf8000000, 32'hf8000000);
    row.value = 32'h7fffffff;
    dir_table.push_back(row);
    row.known = 1'b0;
    row.item = interp_item(32'hffffffff, 32'hffffffff, 32'hffffffff);
    dir_table.push_back(row);
    row.item = interp_item(32'h04000000, 32'h07ffffff, 32'h0);
    dir_table.push_back(row);
    row.item = write_item(32'h1234, 32'h0000ffff);
    dir_table.push_back(row);
    row.item = interp_item(32'hf5555555, 32'h0aaaaaaa, 32'h0c000000);
    dir_table.push_back(row);
    for (int k = 0; k < dir_table.size(); k++)
      send(dir_table[k].item, dir_table[k].known, dir_table[k].value);

    set_mode(MODE_TRIQUAD);
    for (int k = 3; k < dir_table.size(); k++)
      send(dir_table[k].item, dir_table[k].known, dir_table[k].value);
    set_mode(2'd0);
    send(interp_item(0, 0, 0), 1'b0, '0);
    set_mode(2'd3);
    send(interp_item(32'hffffffff, 0, 0), 1'b0, '0);
    set_mode(MODE_TRILINEAR);

    // random part in phases over the modes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: m = MODE_TRILINEAR;
        1: m = MODE_TRIQUAD;
        2: m = 2'($urandom_range(3));
        default: m = MODE_TRIQUAD;
      endcase
      set_mode(m);
      no_idle = (ph == 5);
      if (ph == 3) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (600) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      n = 75;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(2) == 0) begin
          if ($urandom_range(3) == 0)
            send(write_item($urandom(), pick_sample()), 1'b0, '0);
          else
            send(write_item(region_addr($urandom_range(REGION - 1)), pick_sample()),
                 1'b0, '0);
        end else begin
          send(interp_item(pick_pos(), pick_pos(), pick_pos()), 1'b0, '0);
        end
      end
      if (ph == 6) drain();
    end
    no_idle = 1'b0;
    drain();

    if (mismatch_count == 0 && expected_values.size() == 0)
      $display("grid3d_trilinear_triquadratic_interp: match");
    else
      $display("grid3d_trilinear_triquadratic_interp: mismatch");
    $finish;
  end
endmodule

[grid3d_trilinear_triquadratic_interp.f]
src/gti_pkg.sv
src/gti_if.sv
src/gti_grid_mem.sv
src/grid3d_trilinear_triquadratic_interp.sv
tb/sv/testbench.sv
